[hdl/tca_pkg.sv]
// Package: widths, constants and sequencer states for thruster command allocation.
`timescale 1ns / 1ps
package tca_pkg;
	localparam int unsigned CoordW = 24;
	localparam int unsigned SlotW = 4;
	localparam int unsigned CmdW = 16;
	localparam int unsigned MaxThrusters = 16;
	localparam int unsigned AccW = 128;
	localparam int unsigned MulW = 50;
	// eps = 1e-6 in Q.48
	localparam logic [AccW-1:0] EpsQ48 = AccW'(281474977);

	localparam logic OpLoad = 1'b0;
	localparam logic OpAlloc = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOM,
		ST_TERM,
		ST_CHECK,
		ST_DIV,
		ST_OUT
	} tca_state_t;

	typedef struct packed {
		logic [SlotW-1:0] slot;
		logic [CmdW-1:0] command;
		logic last;
	} tca_result_t;
endpackage

[hdl/tca_if.sv]
// Valid/ready channel interface for the input and result words.
`timescale 1ns / 1ps
interface tca_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hdl/thruster_command_allocation.sv]
// Top level: thruster geometry table and iterative projection sequencer.
//  channel | dir | payload
//  in_ch   | in  | opcode, slot, first_x/y/z, second_x/y/z
//  out_ch  | out | out_slot, command, last_of_run
// A load is taken in idle. An allocate runs per thruster the r x d products,
// the dot and length terms (one product a cycle, the multiplier output
// registered), a compare, 16 restoring division steps unless the command is
// zero or saturated, and an output state, with all products on one shared
// multiplier; output handshake stalls add to this.
// Reset clears the table and the sequencer. A stalled result holds the
// sequencer; no input is taken until the whole run has been delivered.
`timescale 1ns / 1ps
module thruster_command_allocation
	import tca_pkg::*;
#(
	parameter int unsigned ThrCount = MaxThrusters
)(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic opcode,
	input logic [SlotW-1:0] slot,
	input logic signed [CoordW-1:0] first_x,
	input logic signed [CoordW-1:0] first_y,
	input logic signed [CoordW-1:0] first_z,
	input logic signed [CoordW-1:0] second_x,
	input logic signed [CoordW-1:0] second_y,
	input logic signed [CoordW-1:0] second_z,
	output logic out_valid,
	input logic out_ready,
	output logic [SlotW-1:0] out_slot,
	output logic [CmdW-1:0] command,
	output logic last_of_run
);
	localparam int unsigned IdxW = (ThrCount > 1) ? $clog2(ThrCount) : 1;
	localparam int unsigned PW = MulW + CoordW;

	// geometry table, cleared at reset
	logic signed [CoordW-1:0] dir_q [3][ThrCount];
	logic signed [CoordW-1:0] pos_q [3][ThrCount];
	logic signed [CoordW-1:0] frc_q [3];
	logic signed [CoordW-1:0] trq_q [3];

	tca_state_t state_q, state_d;
	logic [IdxW-1:0] idx_q;
	logic [4:0] step_q;
	logic signed [MulW-1:0] mom_q [3];
	logic [AccW-1:0] pos_acc_q, neg_acc_q, den_q;
	logic [CmdW-1:0] quo_q;
	logic last_out;

	logic signed [MulW-1:0] mul_a;
	logic signed [CoordW-1:0] mul_b;
	logic signed [PW-1:0] prod_q;

	tca_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(prod_q));

	logic signed [CoordW-1:0] d0, d1, d2, r0, r1, r2;
	assign d0 = dir_q[0][idx_q];
	assign d1 = dir_q[1][idx_q];
	assign d2 = dir_q[2][idx_q];
	assign r0 = pos_q[0][idx_q];
	assign r1 = pos_q[1][idx_q];
	assign r2 = pos_q[2][idx_q];

	logic idx_last;
	assign idx_last = (idx_q == IdxW'(ThrCount - 1));

	// operand selection: steps 0..5 cross product, 0..14 terms
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_MOM) begin
			unique case (step_q[2:0])
				3'd0: begin mul_a = MulW'(r1); mul_b = d2; end
				3'd1: begin mul_a = MulW'(r2); mul_b = d1; end
				3'd2: begin mul_a = MulW'(r2); mul_b = d0; end
				3'd3: begin mul_a = MulW'(r0); mul_b = d2; end
				3'd4: begin mul_a = MulW'(r0); mul_b = d1; end
				default: begin mul_a = MulW'(r1); mul_b = d0; end
			endcase
		end else begin
			unique case (step_q[3:0])
				4'd0: begin mul_a = MulW'(d0); mul_b = frc_q[0]; end
				4'd1: begin mul_a = MulW'(d1); mul_b = frc_q[1]; end
				4'd2: begin mul_a = MulW'(d2); mul_b = frc_q[2]; end
				4'd3: begin mul_a = MulW'(d0); mul_b = d0; end
				4'd4: begin mul_a = MulW'(d1); mul_b = d1; end
				4'd5: begin mul_a = MulW'(d2); mul_b = d2; end
				4'd6: begin mul_a = mom_q[0]; mul_b = trq_q[0]; end
				4'd7: begin mul_a = mom_q[1]; mul_b = trq_q[1]; end
				4'd8: begin mul_a = mom_q[2]; mul_b = trq_q[2]; end
				// m*m split: m = mh*2^24 + ml, ml unsigned 24 bits
				4'd9: begin mul_a = mom_q[0]; mul_b = mom_q[0][CoordW-1:0]; end
				4'd10: begin mul_a = mom_q[1]; mul_b = mom_q[1][CoordW-1:0]; end
				4'd11: begin mul_a = mom_q[2]; mul_b = mom_q[2][CoordW-1:0]; end
				4'd12: begin mul_a = mom_q[0]; mul_b = mom_q[0][2*CoordW-1:CoordW]; end
				4'd13: begin mul_a = mom_q[1]; mul_b = mom_q[1][2*CoordW-1:CoordW]; end
				4'd14: begin mul_a = mom_q[2]; mul_b = mom_q[2][2*CoordW-1:CoordW]; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	// m*ml is formed as m*s with s the low part read signed; ml - s = 2^24*ml[23]
	// m*mh carries weight 2^24
	logic [AccW-1:0] prod_ext, prod_mag, term;
	logic prod_neg;
	logic [4:0] tstep;  // step whose product is now in prod_q
	logic [1:0] mm_idx;
	assign tstep = step_q - 5'd1;
	assign mm_idx = 2'(tstep - 5'd9);
	always_comb begin
		prod_ext = AccW'(signed'(prod_q));
		if (state_q == ST_TERM && tstep >= 5'd9 && tstep <= 5'd11) begin
			if (mom_q[mm_idx][CoordW-1])
				prod_ext = prod_ext + (AccW'(signed'(mom_q[mm_idx])) << CoordW);
		end
		prod_neg = prod_ext[AccW-1];
		prod_mag = prod_neg ? (~prod_ext + AccW'(1)) : prod_ext;
		if (tstep <= 5'd5 || (tstep >= 5'd12 && tstep <= 5'd14)) term = prod_mag << CoordW;
		else if (tstep <= 5'd8) term = prod_mag << 12;
		else term = prod_mag;
	end

	logic [AccW-1:0] num, rem_sh, rem_sub;
	assign num = pos_acc_q - neg_acc_q;
	assign rem_sh = pos_acc_q << 1;
	assign rem_sub = rem_sh - den_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && opcode == OpAlloc) state_d = ST_MOM;
			ST_MOM: if (step_q == 5'd6) state_d = ST_TERM;
			ST_TERM: if (step_q == 5'd15) state_d = ST_CHECK;
			ST_CHECK: begin
				if (neg_acc_q >= pos_acc_q || num >= den_q) state_d = ST_OUT;
				else state_d = ST_DIV;
			end
			ST_DIV: if (step_q == 5'd15) state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = idx_last ? ST_IDLE : ST_MOM;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		out_slot = SlotW'(idx_q);
		command = quo_q;
		last_of_run = last_out;
	end
	assign last_out = idx_last;

	// table writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				for (int i = 0; i < ThrCount; i++) begin
					dir_q[k][i] <= '0;
					pos_q[k][i] <= '0;
				end
		end else if (in_valid && in_ready && opcode == OpLoad
				&& 32'(slot) < ThrCount) begin
			dir_q[0][IdxW'(slot)] <= first_x;
			dir_q[1][IdxW'(slot)] <= first_y;
			dir_q[2][IdxW'(slot)] <= first_z;
			pos_q[0][IdxW'(slot)] <= second_x;
			pos_q[1][IdxW'(slot)] <= second_y;
			pos_q[2][IdxW'(slot)] <= second_z;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) step_q <= '0;
			else step_q <= step_q + 5'd1;
			if (state_q == ST_IDLE) idx_q <= '0;
			else if (state_q == ST_OUT && out_ready && !idx_last) idx_q <= idx_q + IdxW'(1);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			frc_q[0] <= first_x; frc_q[1] <= first_y; frc_q[2] <= first_z;
			trq_q[0] <= second_x; trq_q[1] <= second_y; trq_q[2] <= second_z;
		end
		unique case (state_q)
			ST_MOM: begin
				pos_acc_q <= '0;
				neg_acc_q <= '0;
				den_q <= EpsQ48;
				quo_q <= '0;
				if (step_q == 5'd1) mom_q[0] <= MulW'(prod_q);
				if (step_q == 5'd2) mom_q[0] <= mom_q[0] - MulW'(prod_q);
				if (step_q == 5'd3) mom_q[1] <= MulW'(prod_q);
				if (step_q == 5'd4) mom_q[1] <= mom_q[1] - MulW'(prod_q);
				if (step_q == 5'd5) mom_q[2] <= MulW'(prod_q);
				if (step_q == 5'd6) mom_q[2] <= mom_q[2] - MulW'(prod_q);
			end
			ST_TERM: begin
				// step 0 still holds a cross product term; nothing to add
				if (step_q != 5'd0) begin
					if (tstep <= 5'd2 || (tstep >= 5'd6 && tstep <= 5'd8)) begin
						if (prod_neg) neg_acc_q <= neg_acc_q + term;
						else pos_acc_q <= pos_acc_q + term;
					end else if (prod_neg) den_q <= den_q - term;
					else den_q <= den_q + term;
				end
			end
			ST_CHECK: begin
				if (neg_acc_q >= pos_acc_q) quo_q <= '0;
				else if (num >= den_q) quo_q <= '1;
				pos_acc_q <= num;
			end
			ST_DIV: begin
				if (rem_sh >= den_q) begin
					pos_acc_q <= rem_sub;
					quo_q <= {quo_q[CmdW-2:0], 1'b1};
				end else begin
					pos_acc_q <= rem_sh;
					quo_q <= {quo_q[CmdW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// checks
	a_no_input_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready) else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command))
		else $error("result dropped");
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_of_run |=> state_q == ST_IDLE)
		else $error("run did not end");
endmodule

[hdl/tca_mul.sv]
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module tca_mul
	import tca_pkg::*;
(
	input logic clk,
	input logic signed [MulW-1:0] a,
	input logic signed [CoordW-1:0] b,
	output logic signed [MulW+CoordW-1:0] p_q
);
	// one product per cycle, registered
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

[verif/tb_top.sv]
// Testbench for thruster command allocation: geometry loads and allocate runs checked per result.
`timescale 1ns / 1ps
module tb_top;
	import tca_pkg::*;

	localparam int unsigned NumThr = MaxThrusters;
	localparam int unsigned CycleLimit = 2000000;
	localparam int unsigned HoldOff = 3000;

	typedef struct packed {
		logic opcode;
		logic [SlotW-1:0] slot;
		logic signed [CoordW-1:0] first_x;
		logic signed [CoordW-1:0] first_y;
		logic signed [CoordW-1:0] first_z;
		logic signed [CoordW-1:0] second_x;
		logic signed [CoordW-1:0] second_y;
		logic signed [CoordW-1:0] second_z;
	} in_word_t;

	// directed row: input word and, where obvious, the command for slot 0
	typedef struct {
		in_word_t w;
		int slot0_cmd;
	} stim_row_t;

	typedef logic signed [AccW-1:0] wide_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int unsigned cycles = 0;
	int unsigned fails = 0;
	int unsigned loads = 0;
	int unsigned allocs = 0;
	int unsigned cmds_seen = 0;
	int unsigned cmds_sat = 0;
	int unsigned cmds_mid = 0;
	bit hold_req = 1'b0;

	logic signed [CoordW-1:0] dir_tab [NumThr][3];
	logic signed [CoordW-1:0] pos_tab [NumThr][3];
	tca_result_t cmd_queue [$];

	tca_if #(.payload_t(in_word_t)) in_ch ();
	tca_if #(.payload_t(tca_result_t)) out_ch ();

	thruster_command_allocation u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.opcode(in_ch.payload.opcode),
		.slot(in_ch.payload.slot),
		.first_x(in_ch.payload.first_x),
		.first_y(in_ch.payload.first_y),
		.first_z(in_ch.payload.first_z),
		.second_x(in_ch.payload.second_x),
		.second_y(in_ch.payload.second_y),
		.second_z(in_ch.payload.second_z),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_slot(out_ch.payload.slot),
		.command(out_ch.payload.command),
		.last_of_run(out_ch.payload.last)
	);

	// clock, 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// cycle budget
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// projection of force and torque onto one thruster column, Q0.16 duty
	function automatic logic [CmdW-1:0] duty_for(int k, in_word_t w);
		wide_t d [3];
		wide_t r [3];
		wide_t m [3];
		wide_t f [3];
		wide_t t [3];
		wide_t num;
		wide_t den;
		wide_t q;
		for (int j = 0; j < 3; j++) begin
			d[j] = dir_tab[k][j];
			r[j] = pos_tab[k][j];
		end
		f[0] = w.first_x; f[1] = w.first_y; f[2] = w.first_z;
		t[0] = w.second_x; t[1] = w.second_y; t[2] = w.second_z;
		m[0] = r[1] * d[2] - r[2] * d[1];
		m[1] = r[2] * d[0] - r[0] * d[2];
		m[2] = r[0] * d[1] - r[1] * d[0];
		num = '0;
		den = $signed(EpsQ48);
		for (int j = 0; j < 3; j++) begin
			num = num + ((d[j] * f[j]) <<< 24) + ((m[j] * t[j]) <<< 12);
			den = den + ((d[j] * d[j]) <<< 24) + (m[j] * m[j]);
		end
		if (num <= 0)
			return '0;
		if (num >= den)
			return '1;
		q = (num <<< 16) / den;
		return q[CmdW-1:0];
	endfunction

	// update geometry or queue the commands of an allocate run
	task automatic take_word(in_word_t w, int slot0_cmd);
		tca_result_t r;
		if (w.opcode == OpLoad) begin
			loads++;
			if (w.slot < NumThr) begin
				dir_tab[w.slot] = '{w.first_x, w.first_y, w.first_z};
				pos_tab[w.slot] = '{w.second_x, w.second_y, w.second_z};
			end
		end else begin
			allocs++;
			for (int k = 0; k < NumThr; k++) begin
				r.slot = SlotW'(k);
				r.command = (k == 0 && slot0_cmd >= 0) ? CmdW'(slot0_cmd) : duty_for(k, w);
				r.last = (k == NumThr - 1);
				cmd_queue.push_back(r);
			end
		end
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 80);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	task automatic idle_in(int g);
		if (g > 0) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			in_ch.payload = in_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic send_word(in_word_t w, int slot0_cmd);
		@(negedge clk);
		in_ch.payload = w;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		take_word(w, slot0_cmd);
	endtask

	function automatic logic signed [CoordW-1:0] near(int span);
		return CoordW'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		int ax;
		w = in_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		w.opcode = ($urandom_range(0, 9) < 3) ? OpLoad : OpAlloc;
		// mostly well-scaled geometry and demands, some full range
		if ($urandom_range(0, 4) != 0) begin
			if (w.opcode == OpLoad) begin
				ax = $urandom_range(0, 2);
				w.first_x = near(64);
				w.first_y = near(64);
				w.first_z = near(64);
				case (ax)
					0: w.first_x = $urandom_range(0, 1) ? 24'sd4096 : -24'sd4096;
					1: w.first_y = $urandom_range(0, 1) ? 24'sd4096 : -24'sd4096;
					default: w.first_z = $urandom_range(0, 1) ? 24'sd4096 : -24'sd4096;
				endcase
				w.second_x = near(16384);
				w.second_y = near(16384);
				w.second_z = near(16384);
			end else begin
				w.first_x = near(8192);
				w.first_y = near(8192);
				w.first_z = near(8192);
				w.second_x = near(8192);
				w.second_y = near(8192);
				w.second_z = near(8192);
			end
		end
		return w;
	endfunction

	// result checker
	always @(posedge clk) begin
		tca_result_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			cmds_seen++;
			if (cmd_queue.size() == 0) begin
				$error("unexpected command slot %0d value %0d",
					out_ch.payload.slot, out_ch.payload.command);
				fails++;
			end else begin
				e = cmd_queue.pop_front();
				if (out_ch.payload.command == '1)
					cmds_sat++;
				else if (out_ch.payload.command != '0)
					cmds_mid++;
				if (out_ch.payload.slot !== e.slot) begin
					$error("out_slot: expected %0d actual %0d", e.slot, out_ch.payload.slot);
					fails++;
				end
				if (out_ch.payload.command !== e.command) begin
					$error("command: expected %0d actual %0d", e.command,
						out_ch.payload.command);
					fails++;
				end
				if (out_ch.payload.last !== e.last) begin
					$error("last_of_run: expected %0d actual %0d", e.last,
						out_ch.payload.last);
					fails++;
				end
			end
		end
	end

	// result side: random stalls, quiet stretches, one long hold-off
	initial begin
		int g;
		bit held;
		held = 1'b0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_ch.ready = 1'b0;
				repeat (HoldOff) @(negedge clk);
			end else if ($urandom_range(0, 9) == 0) begin
				out_ch.ready = 1'b1;
				repeat ($urandom_range(50, 300)) @(negedge clk);
			end else begin
				g = gap_len();
				out_ch.ready = (g == 0);
				repeat (g > 0 ? g - 1 : 0) @(negedge clk);
				if (g > 0) begin
					@(negedge clk);
					out_ch.ready = 1'b1;
					repeat ($urandom_range(0, 6)) @(negedge clk);
				end
			end
		end
	end

	// stimulus
	initial begin
		stim_row_t rows [$];
		in_word_t w;
		localparam logic signed [CoordW-1:0] Pmax = 24'sh7FFFFF;
		localparam logic signed [CoordW-1:0] Nmin = 24'sh800000;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		for (int k = 0; k < NumThr; k++) begin
			dir_tab[k] = '{default: '0};
			pos_tab[k] = '{default: '0};
		end
		repeat (10) @(posedge clk);
		arst_n = 1'b1;

		// directed part
		// empty table: every column is zero, so only eps remains
		rows.push_back('{'{OpAlloc, 4'd0, Pmax, Pmax, Pmax, Pmax, Pmax, Pmax}, 0});
		rows.push_back('{'{OpLoad, 4'd0, 24'sd4096, 0, 0, 0, 0, 0}, -1});
		rows.push_back('{'{OpAlloc, 4'd9, Pmax, 0, 0, 0, 0, 0}, 65535});
		rows.push_back('{'{OpAlloc, 4'd0, Nmin, 0, 0, 0, 0, 0}, 0});
		rows.push_back('{'{OpAlloc, 4'd0, 24'sd2048, 0, 0, 0, 0, 0}, -1});
		rows.push_back('{'{OpAlloc, 4'd0, 24'sd4096, 0, 0, 0, 0, 0}, -1});
		rows.push_back('{'{OpLoad, 4'd15, Pmax, Nmin, Pmax, Nmin, Pmax, Nmin}, -1});
		rows.push_back('{'{OpAlloc, 4'd15, Pmax, Nmin, Pmax, Nmin, Pmax, Nmin}, -1});
		rows.push_back('{'{OpAlloc, 4'd3, Nmin, Pmax, Nmin, Pmax, Nmin, Pmax}, 0});
		rows.push_back('{'{OpLoad, 4'd7, 0, 0, 24'sd4096, 0, 24'sd4096, 0}, -1});
		rows.push_back('{'{OpAlloc, 4'd0, 0, 0, 24'sd1024, 24'sd2048, 0, 0}, 0});
		rows.push_back('{'{OpAlloc, 4'd0, 0, 0, 0, 0, 0, 0}, 0});
		rows.push_back('{'{OpLoad, 4'd3, -24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1,
			-24'sd1}, -1});
		rows.push_back('{'{OpAlloc, 4'd0, -24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1,
			-24'sd1}, 0});
		// all-zero thruster after reload
		rows.push_back('{'{OpLoad, 4'd0, 0, 0, 0, 0, 0, 0}, -1});
		rows.push_back('{'{OpAlloc, 4'd0, Pmax, Pmax, Pmax, Pmax, Pmax, Pmax}, 0});
		foreach (rows[i]) begin
			send_word(rows[i].w, rows[i].slot0_cmd);
			idle_in(gap_len());
		end

		// random part; result side holds off early so the block backs up
		hold_req = 1'b1;
		for (int n = 0; n < 200; n++) begin
			// stop offering once until the block has drained
			if (n == 120) begin
				@(negedge clk);
				in_ch.valid = 1'b0;
				while (cmd_queue.size() != 0) @(posedge clk);
			end
			w = rand_word();
			send_word(w, -1);
			idle_in(gap_len());
		end
		@(negedge clk);
		in_ch.valid = 1'b0;

		while (cmd_queue.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d loads and %0d allocate runs, %0d commands checked",
			loads, allocs, cmds_seen);
		$display("saturated commands %0d, fractional commands %0d", cmds_sat, cmds_mid);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
